// ===== rtl/core/zsr_pkg.sv =====
// Shared types, codes and constants of the zoned sector remapper.
`default_nettype none

package zsr_pkg;

	// Fixed field widths
	localparam int SECTOR_PORT_W = 48;
	localparam int LEN_W         = 23;
	localparam int ZS_W          = 31;
	localparam int SH_W          = 5;

	// Defaults
	localparam int SECTOR_BITS_DEF = 48;
	localparam int QUEUE_DEPTH     = 4;
	localparam logic [ZS_W-1:0] ZONE_SECTORS_RST = ZS_W'(196608);
	localparam logic [SH_W-1:0] ZONE_SHIFT_RST   = SH_W'(18);

	typedef enum logic [0:0] {
		CMD_MAP  = 1'b0,
		CMD_DONE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_APPEND = 3'd2,
		OP_MGMT   = 3'd3,
		OP_OTHER  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ACT_FWD  = 2'd0,
		ACT_ZERO = 2'd1,
		ACT_KILL = 2'd2
	} act_t;

	typedef enum logic [0:0] {
		REG_ZONE_SECTORS = 1'b0,
		REG_ZONE_SHIFT   = 1'b1
	} reg_t;

	// How the back end builds the result sector
	typedef enum logic [2:0] {
		KIND_PASS  = 3'd0,	// sector unchanged, forwarded
		KIND_ZERO  = 3'd1,	// read past zone end, zero-filled
		KIND_KILL  = 3'd2,	// killed
		KIND_MAP   = 3'd3,	// index * zone size + offset
		KIND_XLATE = 3'd4	// sector + (sector / zone size) * gap
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  len;
		logic              split;
	} cls_t;

	typedef struct packed {
		logic [ZS_W-1:0] zone_sectors;
		logic [SH_W-1:0] zone_shift;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/zsr_front.sv =====
// Front end: accepts requests and classifies them against the zone geometry.
`default_nettype none

module zsr_front
	import zsr_pkg::*;
#(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cfg_t                     cfg,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic                     cmd,
	input  wire logic [SECTOR_PORT_W-1:0] sector,
	input  wire logic [LEN_W-1:0]         size_sectors,
	input  wire logic [2:0]               op_kind,
	input  wire logic                     status_ok,
	input  wire logic                     q_full,
	output logic                          enq,
	output logic [SECTOR_BITS-1:0]        enq_sec,
	output cls_t                          enq_cls
);

	logic [SECTOR_BITS-1:0] sec_w;
	logic [ZS_W-1:0]        rel;
	logic [ZS_W-1:0]        rest;
	logic                   fits;
	logic                   past;
	logic                   go;
	cls_t                   cls;

	logic                   fr_v_s1;
	logic [SECTOR_BITS-1:0] fr_sec_s1;
	cls_t                   fr_cls_s1;

	// Offset within the emulated zone (spacing is at most 2^31)
	assign sec_w = SECTOR_BITS'(sector);
	assign rel   = sec_w[ZS_W-1:0] & ((ZS_W'(1) << cfg.zone_shift) - ZS_W'(1));
	assign fits  = ({1'b0, rel} + (ZS_W + 1)'(size_sectors)) <= {1'b0, cfg.zone_sectors};
	assign past  = rel >= cfg.zone_sectors;
	assign rest  = cfg.zone_sectors - rel;

	// Classify
	always_comb begin
		cls.kind  = KIND_PASS;
		cls.len   = size_sectors;
		cls.split = 1'b0;
		if (cmd == CMD_DONE) begin
			if (status_ok && (op_kind == OP_APPEND) && (cfg.zone_sectors != '0)) begin
				cls.kind = KIND_XLATE;
			end
		end else if ((size_sectors == '0) && (op_kind != OP_MGMT)) begin
			cls.kind = KIND_PASS;
		end else if (fits) begin
			cls.kind = KIND_MAP;
		end else if (op_kind == OP_READ) begin
			if (past) begin
				cls.kind = KIND_ZERO;
			end else begin
				cls.kind  = KIND_MAP;
				cls.len   = rest[LEN_W-1:0];
				cls.split = 1'b1;
			end
		end else begin
			cls.kind = KIND_KILL;
			cls.len  = '0;
		end
	end

	// Stage register drains into the queue whenever it has room
	assign go   = !fr_v_s1 || !q_full;
	assign full = !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_v_s1 <= 1'b0;
		end else if (go) begin
			fr_v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (go && push) begin
			fr_sec_s1 <= sec_w;
			fr_cls_s1 <= cls;
		end
	end

	assign enq     = fr_v_s1 && !q_full;
	assign enq_sec = fr_sec_s1;
	assign enq_cls = fr_cls_s1;

endmodule

`default_nettype wire

// ===== rtl/core/zsr_queue.sv =====
// Short queue of classified requests between front and back end.
`default_nettype none

module zsr_queue
	import zsr_pkg::*;
#(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF,
	parameter int DEPTH       = QUEUE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   enq,
	input  wire logic [SECTOR_BITS-1:0] enq_sec,
	input  wire cls_t                   enq_cls,
	output logic                        q_full,
	input  wire logic                   deq,
	output logic                        q_valid,
	output logic [SECTOR_BITS-1:0]      q_sec,
	output cls_t                        q_cls
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [SECTOR_BITS-1:0] sec_q [DEPTH];
	cls_t                   cls_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   do_deq;

	assign q_full  = cnt_q == CNT_W'(DEPTH);
	assign q_valid = cnt_q != '0;
	assign do_deq  = deq && q_valid;
	assign q_sec   = sec_q[rd_ptr_q];
	assign q_cls   = cls_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (enq && !do_deq) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!enq && do_deq) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Entries
	always_ff @(posedge clk) begin
		if (enq) begin
			sec_q[wr_ptr_q] <= enq_sec;
			cls_q[wr_ptr_q] <= enq_cls;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/zsr_back.sv =====
// Back end: pipelined divider, staged multiply-add and the result register.
`default_nettype none

module zsr_back
	import zsr_pkg::*;
#(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   q_valid,
	input  wire logic [SECTOR_BITS-1:0] q_sec,
	input  wire cls_t                   q_cls,
	output logic                        deq,
	output logic                        empty,
	input  wire logic                   pop,
	output logic [1:0]                  action,
	output logic [SECTOR_PORT_W-1:0]    out_sector,
	output logic [LEN_W-1:0]            accept_len,
	output logic                        split
);

	localparam int W = SECTOR_BITS;

	// Whole pipeline moves when the result register is free or being taken
	logic adv;

	// Divider stages: stage i settles quotient bit W-1-i
	logic           dv_v_s   [W];
	logic [W-1:0]   dv_sec_s [W];
	logic [W-1:0]   dv_quo_s [W];
	logic [ZS_W-1:0] dv_rem_s [W];
	cls_t           dv_cls_s [W];

	// Multiply-add stages
	logic            mx_v_s1, mx_v_s2, mx_v_s3, mx_v_s4;
	logic [63:0]     mx_a_s1, mx_a_s2, mx_a_s3;
	logic [63:0]     mx_b_s1, mx_b_s2, mx_b_s3;
	logic [W-1:0]    mx_base_s1;
	logic [63:0]     mx_acc_s2, mx_acc_s3, mx_acc_s4;
	cls_t            mx_cls_s1, mx_cls_s2, mx_cls_s3, mx_cls_s4;

	assign adv = !mx_v_s4 || pop;
	assign deq = adv && q_valid;

	genvar i;
	generate
		for (i = 0; i < W; i++) begin : g_div
			localparam int B = W - 1 - i;
			logic            in_v;
			logic [W-1:0]    in_sec;
			logic [W-1:0]    in_quo;
			logic [ZS_W-1:0] in_rem;
			cls_t            in_cls;
			logic [ZS_W:0]   trial;
			logic            ge;
			logic [W-1:0]    nxt_quo;
			logic [ZS_W-1:0] nxt_rem;

			if (i == 0) begin : g_head
				assign in_v   = q_valid;
				assign in_sec = q_sec;
				assign in_quo = '0;
				assign in_rem = '0;
				assign in_cls = q_cls;
			end else begin : g_link
				assign in_v   = dv_v_s[i-1];
				assign in_sec = dv_sec_s[i-1];
				assign in_quo = dv_quo_s[i-1];
				assign in_rem = dv_rem_s[i-1];
				assign in_cls = dv_cls_s[i-1];
			end

			// One restoring step
			always_comb begin
				trial      = {in_rem, in_sec[B]};
				ge         = trial >= {1'b0, cfg.zone_sectors};
				nxt_rem    = ge ? ZS_W'(trial - {1'b0, cfg.zone_sectors}) : trial[ZS_W-1:0];
				nxt_quo    = in_quo;
				nxt_quo[B] = ge;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[i] <= 1'b0;
				end else if (adv) begin
					dv_v_s[i] <= in_v;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_sec_s[i] <= in_sec;
					dv_quo_s[i] <= nxt_quo;
					dv_rem_s[i] <= nxt_rem;
					dv_cls_s[i] <= in_cls;
				end
			end
		end
	endgenerate

	// Operand select: map uses index and zone size, translate uses quotient and gap
	logic [W-1:0]    sel_sec;
	logic [W-1:0]    sel_idx;
	logic [W-1:0]    sel_gap;
	logic [ZS_W-1:0] sel_rel;
	logic [63:0]     sel_a;
	logic [63:0]     sel_b;
	logic [W-1:0]    sel_base;

	assign sel_sec = dv_sec_s[W-1];
	assign sel_idx = sel_sec >> cfg.zone_shift;
	assign sel_rel = sel_sec[ZS_W-1:0] & ((ZS_W'(1) << cfg.zone_shift) - ZS_W'(1));
	assign sel_gap = (W'(1) << cfg.zone_shift) - W'(cfg.zone_sectors);

	always_comb begin
		sel_a    = '0;
		sel_b    = '0;
		sel_base = sel_sec;
		case (dv_cls_s[W-1].kind)
			KIND_MAP: begin
				sel_a    = 64'(sel_idx);
				sel_b    = 64'(cfg.zone_sectors);
				sel_base = W'(sel_rel);
			end
			KIND_XLATE: begin
				sel_a = 64'(dv_quo_s[W-1]);
				sel_b = 64'(sel_gap);
			end
			default: begin
				sel_a = '0;
			end
		endcase
	end

	// Partial products, one 32x32 multiply per stage, modulo 2^64
	logic [63:0] pp_lo;
	logic [63:0] pp_mid;
	logic [63:0] pp_hi;

	assign pp_lo  = 64'(mx_a_s1[31:0]) * 64'(mx_b_s1[31:0]);
	assign pp_mid = 64'(mx_a_s2[31:0]) * 64'(mx_b_s2[63:32]);
	assign pp_hi  = 64'(mx_a_s3[63:32]) * 64'(mx_b_s3[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_v_s1 <= 1'b0;
			mx_v_s2 <= 1'b0;
			mx_v_s3 <= 1'b0;
			mx_v_s4 <= 1'b0;
		end else if (adv) begin
			mx_v_s1 <= dv_v_s[W-1];
			mx_v_s2 <= mx_v_s1;
			mx_v_s3 <= mx_v_s2;
			mx_v_s4 <= mx_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_a_s1    <= sel_a;
			mx_b_s1    <= sel_b;
			mx_base_s1 <= sel_base;
			mx_cls_s1  <= dv_cls_s[W-1];

			mx_acc_s2  <= pp_lo + 64'(mx_base_s1);
			mx_a_s2    <= mx_a_s1;
			mx_b_s2    <= mx_b_s1;
			mx_cls_s2  <= mx_cls_s1;

			mx_acc_s3  <= mx_acc_s2 + {pp_mid[31:0], 32'd0};
			mx_a_s3    <= mx_a_s2;
			mx_b_s3    <= mx_b_s2;
			mx_cls_s3  <= mx_cls_s2;

			mx_acc_s4  <= mx_acc_s3 + {pp_hi[31:0], 32'd0};
			mx_cls_s4  <= mx_cls_s3;
		end
	end

	// Result register
	logic [W-1:0] res_w;
	act_t         act;

	assign res_w = mx_acc_s4[W-1:0];

	always_comb begin
		case (mx_cls_s4.kind)
			KIND_ZERO: act = ACT_ZERO;
			KIND_KILL: act = ACT_KILL;
			default:   act = ACT_FWD;
		endcase
	end

	assign empty      = !mx_v_s4;
	assign action     = act;
	assign out_sector = SECTOR_PORT_W'(res_w);
	assign accept_len = mx_cls_s4.len;
	assign split      = mx_cls_s4.split;

endmodule

`default_nettype wire

// ===== rtl/core/zoned_sector_remapper_top.sv =====
// Top level of the zoned sector remapper: configuration registers and the three parts.
//
//   channel   direction  handshake          payload
//   request   in         push / full        cmd, sector, size_sectors, op_kind, status_ok
//   result    out        empty / pop        action, out_sector, accept_len, split
//   config    in         cfg_we             cfg_addr, cfg_data
//
// One request per cycle sustained while results are taken; empty falls once a request has
// passed the queue write, the SECTOR_BITS-stage restoring divider of the back end (one
// divider stage per sector bit), the operand register and three multiply-add stages.
// Reset clears all valid bits and loads the default zone geometry; no clearing pass.
// A stalled result holds the whole back pipeline; the front keeps taking requests
// until the four-entry queue and the front stage register are full.
`default_nettype none

module zoned_sector_remapper_top
	import zsr_pkg::*;
#(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic                     cmd,
	input  wire logic [SECTOR_PORT_W-1:0] sector,
	input  wire logic [LEN_W-1:0]         size_sectors,
	input  wire logic [2:0]               op_kind,
	input  wire logic                     status_ok,
	output logic                          empty,
	input  wire logic                     pop,
	output logic [1:0]                    action,
	output logic [SECTOR_PORT_W-1:0]      out_sector,
	output logic [LEN_W-1:0]              accept_len,
	output logic                          split,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_addr,
	input  wire logic [ZS_W-1:0]          cfg_data
);

	cfg_t                   cfg_q;
	logic                   q_full;
	logic                   enq;
	logic [SECTOR_BITS-1:0] enq_sec;
	cls_t                   enq_cls;
	logic                   deq;
	logic                   q_valid;
	logic [SECTOR_BITS-1:0] q_sec;
	cls_t                   q_cls;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zone_sectors <= ZONE_SECTORS_RST;
			cfg_q.zone_shift   <= ZONE_SHIFT_RST;
		end else if (cfg_we) begin
			case (reg_t'(cfg_addr))
				REG_ZONE_SECTORS: cfg_q.zone_sectors <= cfg_data;
				REG_ZONE_SHIFT:   cfg_q.zone_shift   <= cfg_data[SH_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	zsr_front #(
		.SECTOR_BITS (SECTOR_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.sector       (sector),
		.size_sectors (size_sectors),
		.op_kind      (op_kind),
		.status_ok    (status_ok),
		.q_full       (q_full),
		.enq          (enq),
		.enq_sec      (enq_sec),
		.enq_cls      (enq_cls)
	);

	zsr_queue #(
		.SECTOR_BITS (SECTOR_BITS),
		.DEPTH       (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_sec (enq_sec),
		.enq_cls (enq_cls),
		.q_full  (q_full),
		.deq     (deq),
		.q_valid (q_valid),
		.q_sec   (q_sec),
		.q_cls   (q_cls)
	);

	zsr_back #(
		.SECTOR_BITS (SECTOR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_sec      (q_sec),
		.q_cls      (q_cls),
		.deq        (deq),
		.empty      (empty),
		.pop        (pop),
		.action     (action),
		.out_sector (out_sector),
		.accept_len (accept_len),
		.split      (split)
	);

endmodule

`default_nettype wire

// ===== rtl/core/zsr_checker.sv =====
// Port-level checks on the result channel of the remapper, bound to the top level.
`default_nettype none

module zsr_checker
	import zsr_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     empty,
	input wire logic                     pop,
	input wire logic [1:0]               action,
	input wire logic [SECTOR_PORT_W-1:0] out_sector,
	input wire logic [LEN_W-1:0]         accept_len,
	input wire logic                     split
);

	// Only the three defined action codes leave the block
	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (action == ACT_FWD || action == ACT_ZERO || action == ACT_KILL))
		else $error("undefined action code on result");

	// A killed request accepts nothing and is never split
	a_kill_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && action == ACT_KILL) |-> (accept_len == '0 && !split))
		else $error("killed request with nonzero length or split");

	// Only a forwarded read can be cut at the zone end, and never to zero length
	a_split_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && split) |-> (action == ACT_FWD && accept_len != '0))
		else $error("split flag on a non-forwarded or empty result");

	// A waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_sector) && $stable(accept_len)
			&& $stable(action) && $stable(split)))
		else $error("waiting result changed before it was taken");

endmodule

bind zoned_sector_remapper_top zsr_checker u_zsr_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the zoned sector remapper: directed and random requests checked by a predictor.
module testbench;
	import zsr_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 7;
	localparam int LATENCY        = SECTOR_BITS_DEF + 10;
	localparam int HOLD_CYCLES    = 400;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int MAX_PRINTS     = 100;
	localparam int N_PHASES       = 7;

	localparam longint unsigned DEF_ZONE    = 64'(ZONE_SECTORS_RST);
	localparam longint unsigned DEF_SPACING = 64'd1 << ZONE_SHIFT_RST;

	// Zone geometry per phase: reset default, extremes, and zones wider than the spacing
	localparam logic [ZS_W-1:0] PHASE_ZONE [N_PHASES] = '{ZONE_SECTORS_RST, 31'd3, 31'd1000,
		31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd5, 31'd100000000};
	localparam logic [SH_W-1:0] PHASE_SHIFT [N_PHASES] = '{ZONE_SHIFT_RST, 5'd2, 5'd10,
		5'd31, 5'd2, 5'd3, 5'd27};
	localparam int PHASE_ITEMS [N_PHASES] = '{180, 150, 200, 200, 150, 150, 230};

	typedef struct packed {
		cmd_t              cmd;
		logic [47:0]       sector;
		logic [LEN_W-1:0]  size;
		logic [2:0]        op;
		logic              ok;
	} request_t;

	typedef struct packed {
		act_t              action;
		logic [47:0]       sector;
		logic [LEN_W-1:0]  len;
		logic              split;
	} remap_result_t;

	// Expected-result store with its own copy of the zone geometry
	class remap_scoreboard;
		logic [ZS_W-1:0] zone_size;
		logic [SH_W-1:0] shift;
		remap_result_t   expected_q[$];
		int unsigned     mismatches, results_checked;
		int unsigned     n_remap, n_split, n_zero, n_kill, n_empty, n_xlate;

		function new();
			zone_size = ZONE_SECTORS_RST;
			shift = ZONE_SHIFT_RST;
		endfunction

		// Translation of one request under the current geometry
		function remap_result_t remap(request_t r);
			logic [63:0] sec, spacing, gap, idx, rel, dev, zsz, len;
			logic [2:0] op;
			remap_result_t res;
			sec = {16'b0, r.sector};
			zsz = {33'b0, zone_size};
			len = {41'b0, r.size};
			spacing = 64'd1 << shift;
			gap = spacing - zsz;
			op = (r.op > OP_OTHER) ? OP_OTHER : r.op;
			res.action = ACT_FWD;
			res.sector = r.sector;
			res.len = r.size;
			res.split = 1'b0;
			// completion: successful appends go back into the emulated space
			if (r.cmd == CMD_DONE) begin
				if (r.ok && op == OP_APPEND && zsz != 0) begin
					res.sector = 48'(sec + (sec / zsz) * gap);
					n_xlate++;
				end
				return res;
			end
			// empty request passes unless it is zone management
			if (len == 0 && op != OP_MGMT) begin
				res.len = '0;
				n_empty++;
				return res;
			end
			idx = sec >> shift;
			rel = sec & (spacing - 64'd1);
			dev = idx * zsz + rel;
			if (rel + len <= zsz) begin
				res.sector = 48'(dev);
				n_remap++;
			end else if (op == OP_READ) begin
				if (rel >= zsz) begin
					res.action = ACT_ZERO;
					n_zero++;
				end else begin
					res.sector = 48'(dev);
					res.len = 23'(zsz - rel);
					res.split = 1'b1;
					n_split++;
				end
			end else begin
				res.action = ACT_KILL;
				res.len = '0;
				n_kill++;
			end
			return res;
		endfunction

		function void note_request(request_t r);
			expected_q.push_back(remap(r));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			if (mismatches <= MAX_PRINTS)
				$display("mismatch %s at result %0d: got 0x%0h, expected 0x%0h",
					what, results_checked, got, want);
		endtask

		task check_result(remap_result_t got);
			remap_result_t want;
			results_checked++;
			if (expected_q.size() == 0) begin
				report("result with no request outstanding", 64'(got.sector), 64'd0);
				return;
			end
			want = expected_q.pop_front();
			if (got.action !== want.action)
				report("action", 64'(got.action), 64'(want.action));
			if (got.sector !== want.sector)
				report("out_sector", 64'(got.sector), 64'(want.sector));
			if (got.len !== want.len)
				report("accept_len", 64'(got.len), 64'(want.len));
			if (got.split !== want.split)
				report("split", 64'(got.split), 64'(want.split));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              cmd = 1'b0;
	logic [47:0]       sector = '0;
	logic [LEN_W-1:0]  size_sectors = '0;
	logic [2:0]        op_kind = '0;
	logic              status_ok = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [1:0]        action;
	logic [47:0]       out_sector;
	logic [LEN_W-1:0]  accept_len;
	logic              split;
	logic              cfg_we = 1'b0;
	logic              cfg_addr = 1'b0;
	logic [ZS_W-1:0]   cfg_data = '0;

	remap_scoreboard   sb;
	remap_result_t     seen;
	int unsigned       send_idle_pct = 0;
	int unsigned       recv_idle_pct = 0;
	int unsigned       items_sent = 0;
	int unsigned       stall_cycles = 0;
	bit                hold_req = 1'b0;
	bit                holding = 1'b0;

	zoned_sector_remapper_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.sector       (sector),
		.size_sectors (size_sectors),
		.op_kind      (op_kind),
		.status_ok    (status_ok),
		.empty        (empty),
		.pop          (pop),
		.action       (action),
		.out_sector   (out_sector),
		.accept_len   (accept_len),
		.split        (split),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Result side: check what was taken at this edge, then pick the next pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				seen.action = act_t'(action);
				seen.sector = out_sector;
				seen.len = accept_len;
				seen.split = split;
				sb.check_result(seen);
			end
			if (push && full)
				stall_cycles++;
			pop <= !holding && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps pushing meanwhile
	initial begin
		forever begin
			wait (hold_req);
			holding = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding = 1'b0;
			hold_req = 1'b0;
		end
	end

	initial begin
		#(2 * CLK_HALF * TIMEOUT_CYCLES);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic request_t mk(cmd_t c, logic [47:0] s, logic [LEN_W-1:0] n,
			logic [2:0] o, logic ok);
		request_t r;
		r.cmd = c;
		r.sector = s;
		r.size = n;
		r.op = o;
		r.ok = ok;
		return r;
	endfunction

	// Random request, steered toward zone ends under the given geometry
	function automatic request_t random_request(logic [ZS_W-1:0] zs, logic [SH_W-1:0] sh);
		request_t r;
		logic [63:0] spacing, zsz, len, base, idx, rel;
		int unsigned pick;
		spacing = 64'd1 << sh;
		zsz = {33'b0, zs};
		r.ok = ($urandom_range(0, 99) < 75);
		pick = $urandom_range(0, 99);
		if (pick < 8)
			r.size = '0;
		else if (pick < 16)
			r.size = '1;
		else if (pick < 40)
			r.size = 23'($urandom_range(1, 4096));
		else
			r.size = 23'($urandom_range(1, 16));
		len = {41'b0, r.size};

		// completions: mostly appends, sectors anywhere in device space
		if ($urandom_range(0, 99) < 20) begin
			r.cmd = CMD_DONE;
			r.op = ($urandom_range(0, 99) < 70) ? OP_APPEND : 3'($urandom_range(0, 7));
			pick = $urandom_range(0, 2);
			if (pick == 0)
				r.sector = rand48();
			else if (pick == 1)
				r.sector = 48'(64'($urandom_range(0, 1 << 20)) * zsz + rand64() % zsz);
			else
				r.sector = 48'($urandom_range(0, 255));
			return r;
		end

		r.cmd = CMD_MAP;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			r.op = OP_READ;
		else if (pick < 55)
			r.op = OP_WRITE;
		else if (pick < 70)
			r.op = OP_APPEND;
		else if (pick < 80)
			r.op = OP_MGMT;
		else
			r.op = 3'($urandom_range(4, 7));

		// zone index: extremes now and then
		pick = $urandom_range(0, 9);
		if (pick == 0)
			idx = '0;
		else if (pick == 1)
			idx = {16'b0, {48{1'b1}}} >> sh;
		else
			idx = {16'b0, rand48()} >> sh;

		// offset within the zone
		base = (len <= zsz) ? zsz - len : '0;
		case ($urandom_range(0, 5))
			0: rel = '0;
			1: rel = rand64() % ((zsz < spacing) ? zsz : spacing);
			2: rel = base + 64'($urandom_range(0, 4)) - ((base >= 2) ? 64'd2 : 64'd0);
			3: rel = (zsz < spacing) ? zsz + rand64() % (spacing - zsz) : rand64() % spacing;
			4: rel = spacing - 64'd1;
			default: rel = rand64() % spacing;
		endcase
		rel &= spacing - 64'd1;
		r.sector = 48'((idx << sh) | rel);

		// a few raw sectors as noise
		if ($urandom_range(0, 9) == 0)
			r.sector = rand48();
		return r;
	endfunction

	// Offer one request, idling first at random; returns at the accepting edge
	task automatic offer(request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= r.cmd;
		sector <= r.sector;
		size_sectors <= r.size;
		op_kind <= r.op;
		status_ok <= r.ok;
		do @(posedge clk); while (full);
		sb.note_request(r);
		items_sent++;
	endtask

	// Wait for every outstanding request to come back, then let the pipe settle
	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic set_geometry(logic [ZS_W-1:0] zs, logic [SH_W-1:0] sh);
		cfg_we <= 1'b1;
		cfg_addr <= REG_ZONE_SECTORS;
		cfg_data <= zs;
		@(posedge clk);
		cfg_addr <= REG_ZONE_SHIFT;
		cfg_data <= ZS_W'(sh);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.zone_size = zs;
		sb.shift = sh;
	endtask

	initial begin
		request_t r;
		request_t directed_q[$];
		int ph;
		int k;
		sb = new();

		// Directed cases under the reset geometry
		directed_q.push_back(mk(CMD_MAP, 48'(5 * DEF_SPACING + 100), 23'd8, OP_READ, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(7 * DEF_SPACING), 23'(DEF_ZONE), OP_WRITE, 1'b0));
		directed_q.push_back(mk(CMD_MAP, 48'(3 * DEF_SPACING + DEF_ZONE - 4), 23'd8, OP_READ, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(3 * DEF_SPACING + DEF_ZONE), 23'd8, OP_READ, 1'b0));
		directed_q.push_back(mk(CMD_MAP, 48'(4 * DEF_SPACING - 1), 23'd1, OP_READ, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(3 * DEF_SPACING + DEF_ZONE - 4), 23'd8, OP_WRITE, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(3 * DEF_SPACING + DEF_ZONE + 16), 23'd8, OP_WRITE, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(2 * DEF_SPACING + 10), 23'd16, OP_APPEND, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(2 * DEF_SPACING + DEF_ZONE - 1), 23'd2, OP_APPEND, 1'b0));
		directed_q.push_back(mk(CMD_MAP, 48'(9 * DEF_SPACING), 23'd0, OP_MGMT, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(9 * DEF_SPACING + DEF_ZONE + 1), 23'd0, OP_MGMT, 1'b0));
		directed_q.push_back(mk(CMD_MAP, 48'(9 * DEF_SPACING + DEF_ZONE + 1), 23'd0, OP_WRITE, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(9 * DEF_SPACING + DEF_ZONE + 1), 23'd0, OP_READ, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(6 * DEF_SPACING + 5), 23'd4, OP_OTHER, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(6 * DEF_SPACING + DEF_ZONE - 1), 23'd4, 3'd7, 1'b1));
		directed_q.push_back(mk(CMD_MAP, 48'(6 * DEF_SPACING + 5), 23'd4, 3'd5, 1'b0));
		directed_q.push_back(mk(CMD_MAP, '1, '1, OP_READ, 1'b1));
		directed_q.push_back(mk(CMD_MAP, '0, '1, OP_READ, 1'b0));
		directed_q.push_back(mk(CMD_MAP, '0, '1, OP_WRITE, 1'b1));
		directed_q.push_back(mk(CMD_DONE, 48'd1000000, 23'd8, OP_APPEND, 1'b1));
		directed_q.push_back(mk(CMD_DONE, 48'd1000000, 23'd8, OP_APPEND, 1'b0));
		directed_q.push_back(mk(CMD_DONE, 48'd1000000, 23'd8, OP_WRITE, 1'b1));
		directed_q.push_back(mk(CMD_DONE, '1, '1, OP_APPEND, 1'b1));
		directed_q.push_back(mk(CMD_DONE, '0, '0, OP_APPEND, 1'b1));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		for (ph = 0; ph < N_PHASES; ph++) begin
			if (ph != 0)
				set_geometry(PHASE_ZONE[ph], PHASE_SHIFT[ph]);
			// idling: sender light/receiver heavy, then swapped, then none
			send_idle_pct = (ph < 3) ? 26 : ((ph < 5) ? 68 : 0);
			recv_idle_pct = (ph < 3) ? 68 : ((ph < 5) ? 26 : 0);
			if (ph == 0)
				foreach (directed_q[i])
					offer(directed_q[i]);
			for (k = 0; k < PHASE_ITEMS[ph]; k++) begin
				if (ph == 2 && k == 30)
					hold_req = 1'b1;
				r = random_request(sb.zone_size, sb.shift);
				offer(r);
			end
			drain();
		end

		if (sb.pending() != 0)
			sb.report("requests left without a result", 64'(sb.pending()), 64'd0);
		$display("covered %0d requests over %0d zone geometries, %0d results checked",
			items_sent, N_PHASES, sb.results_checked);
		$display("remapped %0d, split %0d, zero-filled %0d, killed %0d, empty %0d, %s %0d, %s %0d",
			sb.n_remap, sb.n_split, sb.n_zero, sb.n_kill, sb.n_empty,
			"appends translated", sb.n_xlate, "input stall cycles", stall_cycles);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
